/* rtl/ssqa_pkg.sv */
// ssqa_pkg: shared types, codes, constants and helpers of the swap space
// quota admission unit; used by every module under rtl
`timescale 1ns / 1ps
`default_nettype none

package ssqa_pkg;

  localparam int MODE_W      = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int IN_TDATA_W  = 240;
  localparam int OUT_TDATA_W = 344;

  localparam logic [63:0] QUOTA_DEFAULT_BYTES      = 64'd1073741824;
  localparam logic [63:0] FREE_FLOOR_DEFAULT_BYTES = 64'd104857600;

  localparam logic [CFG_IDX_W-1:0] CFG_SPACE_LIMIT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREE_SPACE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_INTERVAL = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    OP_INIT       = 3'd0,
    OP_RESERVE    = 3'd1,
    OP_CANCEL     = 3'd2,
    OP_COMMIT     = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_REMOVE_ALL = 3'd5,
    OP_STATS      = 3'd6,
    OP_NONE       = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOSPC = 2'd1,
    ST_QUOTA = 2'd2
  } status_t;

  typedef struct packed {
    logic [63:0] space_limit;
    logic [63:0] min_free_space;
    logic [31:0] refresh_interval_ms;
  } cfg_t;

  // classified event as it waits in the queue
  typedef struct packed {
    op_t         op;
    logic [47:0] now_ms;
    logic        free_valid;
    logic [62:0] free_space;
    logic [63:0] data_size;
    logic [63:0] occupied_size;
    logic        fresh_on;        // reported free space meets the threshold
    logic [63:0] fresh_writable;  // reported free space above the threshold
    logic [63:0] limit;           // effective quota
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] entry_count;
    logic [63:0] data_total;
    logic [63:0] occupied_total;
    logic        enabled;
    logic        disable_cause;
    logic [63:0] written_total;
    logic [47:0] last_check_ms;
    logic [63:0] device_free;
  } res_t;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  function automatic logic [63:0] sat_sub64(input logic [63:0] a, input logic [63:0] b);
    return (a >= b) ? (a - b) : 64'd0;
  endfunction

endpackage

`default_nettype wire

/* rtl/ssqa_front.sv */
// ssqa_front: unpacks an incoming event, decodes its mode and precomputes
// the parts that depend only on the item and configuration; uses ssqa_pkg
`timescale 1ns / 1ps
`default_nettype none

module ssqa_front
  import ssqa_pkg::*;
(
  input  wire logic                  s_tvalid,
  output      logic                  s_tready,
  input  wire logic [IN_TDATA_W-1:0] s_tdata,
  input  wire logic [MODE_W-1:0]     s_tuser,
  input  wire cfg_t                  cfg,
  input  wire logic                  q_full,
  output      logic                  push,
  output      cmd_t                  cmd
);

  logic [62:0] free_space;

  assign free_space = s_tdata[111:49];
  assign s_tready   = !q_full;
  assign push       = s_tvalid && !q_full;

  always_comb begin
    cmd.op             = op_t'(s_tuser);
    cmd.now_ms         = s_tdata[47:0];
    cmd.free_valid     = s_tdata[48];
    cmd.free_space     = free_space;
    cmd.data_size      = s_tdata[175:112];
    cmd.occupied_size  = s_tdata[239:176];
    cmd.fresh_on       = {1'b0, free_space} >= cfg.min_free_space;
    cmd.fresh_writable = sat_sub64({1'b0, free_space}, cfg.min_free_space);
    // zero limit selects the default quota
    cmd.limit          = (cfg.space_limit != 64'd0) ? cfg.space_limit
                                                    : QUOTA_DEFAULT_BYTES;
  end

endmodule

`default_nettype wire

/* rtl/ssqa_queue.sv */
// ssqa_queue: small first-in first-out queue of classified events between
// front and back; uses ssqa_pkg for the entry type
`timescale 1ns / 1ps
`default_nettype none

module ssqa_queue
  import ssqa_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t din,
  input  wire logic pop,
  output      logic full,
  output      logic not_empty,
  output      cmd_t dout
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign dout      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/ssqa_back.sv */
// ssqa_back: unless a held result stalls it, executes one event a cycle against the
// byte counters, free space refresh and admission check, holds the result register; uses ssqa_pkg
`timescale 1ns / 1ps
`default_nettype none

module ssqa_back
  import ssqa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic q_valid,
  input  wire cmd_t cmd,
  output      logic q_pop,
  output      logic out_valid,
  input  wire logic out_ready,
  output      res_t res
);

  logic [31:0] count_entries, count_entries_next;
  logic [63:0] sum_data, sum_data_next;
  logic [63:0] sum_occupied, sum_occupied_next;
  logic [63:0] sum_pending, sum_pending_next;
  logic [63:0] in_flight, in_flight_next;
  logic [63:0] sum_written, sum_written_next;
  logic [63:0] known_free, known_free_next;
  logic [47:0] check_time, check_time_next;
  logic        feature_on, feature_on_next;
  logic        off_cause, off_cause_next;
  status_t     status;

  logic [48:0] elapsed;
  logic        due;
  logic        load;
  logic        cur_on;
  logic        on_eff;
  logic [63:0] writable_eff;
  logic [63:0] in_flight_eff;
  logic [65:0] quota_sum;
  logic [65:0] space_sum;
  logic        quota_fail;
  logic        space_fail;
  logic        init_on;

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    // refresh decision; time running backwards skips it unless the interval is zero
    elapsed = {1'b0, cmd.now_ms} - {1'b0, check_time};
    due     = (cfg.refresh_interval_ms == 32'd0) ||
              (!elapsed[48] && (elapsed[47:0] >= {16'd0, cfg.refresh_interval_ms}));
    load    = due && cmd.free_valid;
    cur_on  = known_free >= cfg.min_free_space;
    on_eff  = due ? (load ? cmd.fresh_on : cur_on) : feature_on;
    writable_eff  = load ? cmd.fresh_writable : sat_sub64(known_free, cfg.min_free_space);
    in_flight_eff = load ? 64'd0 : in_flight;

    // a carry past 64 bits always exceeds the compare bound
    quota_sum  = {2'b0, cmd.occupied_size} + {2'b0, sum_occupied} + {2'b0, sum_pending};
    quota_fail = quota_sum > {2'b0, cmd.limit};
    space_sum  = {2'b0, cmd.occupied_size} + {2'b0, sum_pending} + {2'b0, in_flight_eff};
    space_fail = space_sum > {2'b0, writable_eff};
    init_on    = cmd.free_valid ? cmd.fresh_on : (cfg.min_free_space == 64'd0);

    count_entries_next = count_entries;
    sum_data_next      = sum_data;
    sum_occupied_next  = sum_occupied;
    sum_pending_next   = sum_pending;
    in_flight_next     = in_flight;
    sum_written_next   = sum_written;
    known_free_next    = known_free;
    check_time_next    = check_time;
    feature_on_next    = feature_on;
    off_cause_next     = off_cause;
    status             = ST_OK;

    case (cmd.op)
      OP_INIT: begin
        count_entries_next = '0;
        sum_data_next      = '0;
        sum_occupied_next  = '0;
        sum_pending_next   = '0;
        in_flight_next     = '0;
        sum_written_next   = '0;
        check_time_next    = cmd.now_ms;
        known_free_next    = cmd.free_valid ? {1'b0, cmd.free_space} : 64'd0;
        feature_on_next    = init_on;
        off_cause_next     = !init_on;
      end
      OP_RESERVE, OP_STATS: begin
        if (due) begin
          check_time_next = cmd.now_ms;
          feature_on_next = on_eff;
          off_cause_next  = !on_eff;
        end
        if (load) begin
          known_free_next = {1'b0, cmd.free_space};
          in_flight_next  = '0;
        end
        if (cmd.op == OP_RESERVE) begin
          if (!on_eff) begin
            status = ST_NOSPC;
          end else if (quota_fail) begin
            status = ST_QUOTA;
          end else if (space_fail) begin
            status = ST_NOSPC;
          end else begin
            sum_pending_next = sat_add64(sum_pending, cmd.occupied_size);
          end
        end
      end
      OP_CANCEL: begin
        sum_pending_next = sat_sub64(sum_pending, cmd.occupied_size);
      end
      OP_COMMIT: begin
        sum_pending_next   = sat_sub64(sum_pending, cmd.occupied_size);
        count_entries_next = (count_entries == {32{1'b1}}) ? count_entries
                                                           : count_entries + 32'd1;
        sum_data_next      = sat_add64(sum_data, cmd.data_size);
        sum_occupied_next  = sat_add64(sum_occupied, cmd.occupied_size);
        sum_written_next   = sat_add64(sum_written, cmd.occupied_size);
        in_flight_next     = sat_add64(in_flight, cmd.occupied_size);
      end
      OP_REMOVE: begin
        count_entries_next = (count_entries != 32'd0) ? count_entries - 32'd1 : 32'd0;
        sum_data_next      = sat_sub64(sum_data, cmd.data_size);
        sum_occupied_next  = sat_sub64(sum_occupied, cmd.occupied_size);
      end
      OP_REMOVE_ALL: begin
        count_entries_next = '0;
        sum_data_next      = '0;
        sum_occupied_next  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_entries <= '0;
      sum_data      <= '0;
      sum_occupied  <= '0;
      sum_pending   <= '0;
      in_flight     <= '0;
      sum_written   <= '0;
      known_free    <= '0;
      check_time    <= '0;
      feature_on    <= 1'b0;
      off_cause     <= 1'b1;
      out_valid     <= 1'b0;
    end else begin
      if (q_pop) begin
        count_entries <= count_entries_next;
        sum_data      <= sum_data_next;
        sum_occupied  <= sum_occupied_next;
        sum_pending   <= sum_pending_next;
        in_flight     <= in_flight_next;
        sum_written   <= sum_written_next;
        known_free    <= known_free_next;
        check_time    <= check_time_next;
        feature_on    <= feature_on_next;
        off_cause     <= off_cause_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded with the post-event state
  always_ff @(posedge clk) begin
    if (q_pop) begin
      res.status         <= status;
      res.entry_count    <= count_entries_next;
      res.data_total     <= sum_data_next;
      res.occupied_total <= sum_occupied_next;
      res.enabled        <= feature_on_next;
      res.disable_cause  <= off_cause_next;
      res.written_total  <= sum_written_next;
      res.last_check_ms  <= check_time_next;
      res.device_free    <= known_free_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/swap_space_quota_admission_unit.sv */
// swap_space_quota_admission_unit: top level with configuration registers,
// front decode, event queue and execution back end; uses ssqa_pkg
// an accepted input is written into the queue, then executed into the result register
// throughput: one item per cycle while no held result stalls the back end
// the queue (QUEUE_DEPTH items) lets input be taken while a result waits
// reset: synchronous; counters, free space and check time clear, feature off
`timescale 1ns / 1ps
`default_nettype none

module swap_space_quota_admission_unit
  import ssqa_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  // now_ms[47:0], free_valid[48], free_space[111:49], data_size[175:112],
  // occupied_size[239:176]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // mode[2:0]
  input  wire logic [MODE_W-1:0]      s_axis_tuser,
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // status[1:0], entry_count[33:2], data_total[97:34], occupied_total[161:98],
  // enabled[162], disable_cause[163], written_total[227:164],
  // last_check_ms[275:228], device_free[339:276], zero pad[343:340]
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg;
  cmd_t front_cmd;
  cmd_t q_cmd;
  res_t res;
  logic push;
  logic q_full;
  logic q_valid;
  logic q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.space_limit         <= QUOTA_DEFAULT_BYTES;
      cfg.min_free_space      <= FREE_FLOOR_DEFAULT_BYTES;
      cfg.refresh_interval_ms <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SPACE_LIMIT:      cfg.space_limit         <= cfg_data;
        CFG_MIN_FREE_SPACE:   cfg.min_free_space      <= cfg_data;
        CFG_REFRESH_INTERVAL: cfg.refresh_interval_ms <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  ssqa_front u_front (
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .s_tdata  (s_axis_tdata),
    .s_tuser  (s_axis_tuser),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push),
    .cmd      (front_cmd)
  );

  ssqa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (front_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .dout      (q_cmd)
  );

  ssqa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .cmd       (q_cmd),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {4'b0, res.device_free, res.last_check_ms, res.written_total,
                         res.disable_cause, res.enabled, res.occupied_total,
                         res.data_total, res.entry_count, res.status};

  // enable flag and disable cause always disagree
  a_cause_matches: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[162] != m_axis_tdata[163]))
    else $error("enabled and disable_cause agree");

  // no status code beyond quota exceeded
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'b11))
    else $error("undefined status code");

  // the back end only advances when the result slot is free or being taken
  a_pop_slot: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_valid && (!m_axis_tvalid || m_axis_tready)))
    else $error("event executed while result held");

  // nothing leaves right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire
